// ===== rtl/rdwa_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the square root table for the radial warp address block
package rdwa_pkg;

    localparam int MAX_DIM     = 2048;
    localparam int TABLE_DEPTH = 2048;

    localparam int DIM_W     = 12;                    // width/height register bits
    localparam int COORD_W   = 11;                    // pixel and source coordinates
    localparam int DELTA_W   = COORD_W + 1;           // signed offset from the center
    localparam int N_W       = 2 * DELTA_W;           // squared radius
    localparam int ROOT_W    = 16;
    localparam int TBL_AW    = $clog2(TABLE_DEPTH);
    localparam int IDX_W     = 11;
    localparam int GAIN_W    = 20;
    localparam int PROD_W    = GAIN_W + DELTA_W + 1;  // gain * delta + rounding
    localparam int CRD_SUM_W = PROD_W - 8 + 1;        // center + shifted product
    localparam int FRAC_W    = 8;
    localparam int ADDR_W    = 22;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_BILINEAR_ENABLE = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef struct packed {
        logic                     cmd;
        logic [COORD_W-1:0]       pixel_x;
        logic [COORD_W-1:0]       pixel_y;
        logic [IDX_W-1:0]         entry_index;
        logic signed [GAIN_W-1:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] source_x;
        logic [COORD_W-1:0] source_y;
        logic [ADDR_W-1:0]  source_address;
        logic [FRAC_W-1:0]  frac_x;
        logic [FRAC_W-1:0]  frac_y;
    } out_item_t;

    localparam logic [7:0] ROOT_LUT [256] = '{
        8'd0,   8'd16,  8'd22,  8'd27,  8'd32,  8'd35,  8'd39,  8'd42,
        8'd45,  8'd48,  8'd50,  8'd53,  8'd55,  8'd57,  8'd59,  8'd61,
        8'd64,  8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd75,  8'd76,
        8'd78,  8'd80,  8'd81,  8'd83,  8'd84,  8'd86,  8'd87,  8'd89,
        8'd90,  8'd91,  8'd93,  8'd94,  8'd96,  8'd97,  8'd98,  8'd99,
        8'd101, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd109,
        8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118,
        8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126,
        8'd128, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134,
        8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142,
        8'd143, 8'd144, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149,
        8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155,
        8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162,
        8'd163, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168,
        8'd169, 8'd170, 8'd170, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174,
        8'd175, 8'd176, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179, 8'd180,
        8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185,
        8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191,
        8'd192, 8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196,
        8'd197, 8'd197, 8'd198, 8'd199, 8'd199, 8'd200, 8'd201, 8'd201,
        8'd202, 8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206, 8'd206,
        8'd207, 8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211,
        8'd212, 8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
        8'd217, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221,
        8'd221, 8'd222, 8'd222, 8'd223, 8'd224, 8'd224, 8'd225, 8'd225,
        8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229, 8'd230,
        8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234,
        8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238,
        8'd239, 8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243,
        8'd243, 8'd244, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247,
        8'd247, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251,
        8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255
    };

    // frame dimension limited to 2..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        if (32'(d) < 2) begin
            res = DIM_W'(2);
        end else if (32'(d) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = d;
        end
        return res;
    endfunction

    // coarse root: pick the octave, look up eight bits, rescale
    function automatic logic [ROOT_W-1:0] table_root(input logic [N_W-1:0] n);
        logic [31:0]       v;
        logic [ROOT_W-1:0] r;
        v = 32'(n);
        if (v >= 32'h4000_0000) begin
            r = ROOT_W'(ROOT_LUT[v[31:24]]) << 8;
        end else if (v >= 32'h1000_0000) begin
            r = ROOT_W'(ROOT_LUT[v[29:22]]) << 7;
        end else if (v >= 32'h0400_0000) begin
            r = ROOT_W'(ROOT_LUT[v[27:20]]) << 6;
        end else if (v >= 32'h0100_0000) begin
            r = ROOT_W'(ROOT_LUT[v[25:18]]) << 5;
        end else if (v >= 32'h0040_0000) begin
            r = ROOT_W'(ROOT_LUT[v[23:16]]) << 4;
        end else if (v >= 32'h0010_0000) begin
            r = ROOT_W'(ROOT_LUT[v[21:14]]) << 3;
        end else if (v >= 32'h0004_0000) begin
            r = ROOT_W'(ROOT_LUT[v[19:12]]) << 2;
        end else if (v >= 32'h0001_0000) begin
            r = ROOT_W'(ROOT_LUT[v[17:10]]) << 1;
        end else if (v >= 32'h0000_4000) begin
            r = ROOT_W'(ROOT_LUT[v[15:8]]);
        end else if (v >= 32'h0000_1000) begin
            r = ROOT_W'(ROOT_LUT[v[13:6]]) >> 1;
        end else if (v >= 32'h0000_0400) begin
            r = ROOT_W'(ROOT_LUT[v[11:4]]) >> 2;
        end else begin
            r = ROOT_W'(ROOT_LUT[v[9:2]]) >> 3;
        end
        return r;
    endfunction

endpackage

// ===== rtl/radial_distance_warp_address.sv =====
`timescale 1ns / 1ps
// top level of the radial distance warp address generator
//
// Each input item either writes one entry of the 2048-entry gain table
// (cmd = 0, no result) or maps one output pixel to a source location
// (cmd = 1, one result). For a pixel the block forms the offset from the
// frame center, a squared radius dx*dx - dx + dy*dy + 256, a table-based
// square root of it that selects a gain (signed 12.8 fixed point), and then
// scales the offset by the gain, rounds with a floor shift, re-centers and
// clamps to the frame. The result carries the source column and row, the
// linear address row*width + column, and in bilinear mode the 8-bit
// fractions (the clamp then stops at size-2). The block accepts one item
// every clock unless the output register is full and not taken. The gain
// table sits in a single-port-read ram read once per pixel item, and table
// writes go through the same pipeline slot as the reads, so every pixel sees
// exactly the writes that were accepted before it. The whole pipeline holds
// when the output register is full and not taken. Registers (APB, byte
// addresses): 0x0 image_width, 0x4 image_height, 0x8 bilinear_enable; the user
// must change them only while no item is in flight, which the block does not
// enforce. Gain entries that were never written read as undefined.
module radial_distance_warp_address (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rdwa_pkg::in_item_t                 s_data,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output rdwa_pkg::out_item_t                m_data,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rdwa_pkg::PADDR_W-1:0]       paddr,
    input  logic [rdwa_pkg::PDATA_W-1:0]       pwdata,
    output logic [rdwa_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int DIM_W     = rdwa_pkg::DIM_W;
    localparam int COORD_W   = rdwa_pkg::COORD_W;
    localparam int DELTA_W   = rdwa_pkg::DELTA_W;
    localparam int N_W       = rdwa_pkg::N_W;
    localparam int ROOT_W    = rdwa_pkg::ROOT_W;
    localparam int TBL_AW    = rdwa_pkg::TBL_AW;
    localparam int IDX_W     = rdwa_pkg::IDX_W;
    localparam int GAIN_W    = rdwa_pkg::GAIN_W;
    localparam int PROD_W    = rdwa_pkg::PROD_W;
    localparam int CRD_SUM_W = rdwa_pkg::CRD_SUM_W;
    localparam int FRAC_W    = rdwa_pkg::FRAC_W;
    localparam int ADDR_W    = rdwa_pkg::ADDR_W;
    localparam int PDATA_W   = rdwa_pkg::PDATA_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic             bilinear_enable_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= rdwa_pkg::WIDTH_RESET;
            image_height_reg    <= rdwa_pkg::HEIGHT_RESET;
            bilinear_enable_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                rdwa_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= pwdata[DIM_W-1:0];
                rdwa_pkg::REG_IMAGE_HEIGHT:    image_height_reg    <= pwdata[DIM_W-1:0];
                rdwa_pkg::REG_BILINEAR_ENABLE: bilinear_enable_reg <= pwdata[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rdwa_pkg::REG_IMAGE_WIDTH:     prdata = PDATA_W'(image_width_reg);
            rdwa_pkg::REG_IMAGE_HEIGHT:    prdata = PDATA_W'(image_height_reg);
            rdwa_pkg::REG_BILINEAR_ENABLE: prdata = PDATA_W'(bilinear_enable_reg);
            default:                       prdata = '0;
        endcase
    end

    // effective frame size and center, static while items are in flight
    logic [DIM_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [COORD_W-1:0] half_w;
    logic [COORD_W-1:0] half_h;

    assign eff_w  = rdwa_pkg::eff_dim(image_width_reg);
    assign eff_h  = rdwa_pkg::eff_dim(image_height_reg);
    assign half_w = eff_w[DIM_W-1:1];
    assign half_h = eff_h[DIM_W-1:1];

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together
    // ------------------------------------------------------------------
    logic advance;
    logic accept;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // stage valids and commands
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg, vld7_reg;
    logic m_valid_reg;
    logic cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;

    // payload
    logic signed [DELTA_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [DELTA_W-1:0] dx4_reg, dy4_reg, dx5_reg, dy5_reg;
    logic [IDX_W-1:0]          idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [GAIN_W-1:0]         val1_reg, val2_reg, val3_reg, val4_reg;
    logic [N_W-1:0]            sqx2_reg, sqy2_reg;
    logic [N_W-1:0]            n3_reg;
    logic [TBL_AW-1:0]         root4_reg;
    logic signed [PROD_W-1:0]  px6_reg, py6_reg;
    logic [COORD_W-1:0]        sx7_reg, sy7_reg;
    logic [FRAC_W-1:0]         fx7_reg, fy7_reg;
    rdwa_pkg::out_item_t       m_data_reg;

    // stage 1: offsets from the center
    logic signed [DELTA_W-1:0] dx_next, dy_next;
    assign dx_next = signed'({1'b0, s_data.pixel_x}) - signed'({1'b0, half_w});
    assign dy_next = signed'({1'b0, s_data.pixel_y}) - signed'({1'b0, half_h});

    // stage 2: squared terms, dx*dx - dx is never negative
    logic signed [N_W-1:0] sqx_next, sqy_next;
    assign sqx_next = N_W'(dx1_reg) * N_W'(dx1_reg) - N_W'(dx1_reg);
    assign sqy_next = N_W'(dy1_reg) * N_W'(dy1_reg);

    // stage 3: squared radius
    logic [N_W-1:0] n_next;
    assign n_next = sqx2_reg + sqy2_reg + N_W'(256);

    // stage 4: root, saturated to the last table entry
    logic [ROOT_W-1:0] root_full;
    logic [TBL_AW-1:0] root_next;
    assign root_full = rdwa_pkg::table_root(n3_reg);
    assign root_next = (32'(root_full) >= rdwa_pkg::TABLE_DEPTH)
                     ? TBL_AW'(rdwa_pkg::TABLE_DEPTH - 1) : TBL_AW'(root_full);

    // gain table access, writes and reads in item order at the same slot
    logic              ram_we, ram_re;
    logic [GAIN_W-1:0] ram_rdata;

    assign ram_we = advance && vld4_reg && (cmd4_reg == rdwa_pkg::CMD_WRITE)
                 && (32'(idx4_reg) < rdwa_pkg::TABLE_DEPTH);
    assign ram_re = advance && vld4_reg && (cmd4_reg == rdwa_pkg::CMD_MAP);

    rdwa_ram #(
        .WIDTH (GAIN_W),
        .DEPTH (rdwa_pkg::TABLE_DEPTH)
    ) u_gain_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (TBL_AW'(idx4_reg)),
        .wr_data (val4_reg),
        .rd_en   (ram_re),
        .rd_addr (root4_reg),
        .rd_data (ram_rdata)
    );

    // stage 6: scaled offsets with rounding bias; read data holds while stalled
    logic signed [GAIN_W-1:0] gain;
    logic signed [PROD_W-1:0] px_next, py_next;
    assign gain    = signed'(ram_rdata);
    assign px_next = PROD_W'(gain) * PROD_W'(dx5_reg) + PROD_W'(128);
    assign py_next = PROD_W'(gain) * PROD_W'(dy5_reg) + PROD_W'(128);

    // stage 7: floor shift by 8, re-center, clamp
    logic signed [CRD_SUM_W-1:0] cx, cy;
    logic [COORD_W-1:0]          sx_next, sy_next;
    logic [FRAC_W-1:0]           fx_next, fy_next;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [CRD_SUM_W-1:0] c,
        input logic [DIM_W-1:0]            size,
        input logic                        bilin
    );
        logic signed [CRD_SUM_W-1:0] sz;
        logic [COORD_W-1:0]          res;
        sz = signed'(CRD_SUM_W'(size));
        if (c < 0) begin
            res = '0;
        end else if (bilin && (c >= sz - 1)) begin
            res = COORD_W'(size - DIM_W'(2));
        end else if (!bilin && (c >= sz)) begin
            res = COORD_W'(size - DIM_W'(1));
        end else begin
            res = COORD_W'(c);
        end
        return res;
    endfunction

    // the shifted product keeps its sign
    assign cx = CRD_SUM_W'(signed'({1'b0, half_w}))
              + CRD_SUM_W'(signed'(px6_reg[PROD_W-1:8]));
    assign cy = CRD_SUM_W'(signed'({1'b0, half_h}))
              + CRD_SUM_W'(signed'(py6_reg[PROD_W-1:8]));
    assign sx_next = clamp_coord(cx, eff_w, bilinear_enable_reg);
    assign sy_next = clamp_coord(cy, eff_h, bilinear_enable_reg);
    assign fx_next = bilinear_enable_reg ? px6_reg[FRAC_W-1:0] : '0;
    assign fy_next = bilinear_enable_reg ? py6_reg[FRAC_W-1:0] : '0;

    // stage 8: linear address into the output register
    logic [2*DIM_W-1:0] addr_next;
    assign addr_next = (2*DIM_W)'(sy7_reg) * (2*DIM_W)'(eff_w) + (2*DIM_W)'(sx7_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            vld6_reg    <= 1'b0;
            vld7_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            vld1_reg    <= s_valid;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            vld4_reg    <= vld3_reg;
            // only pixel items go past the table
            vld5_reg    <= vld4_reg && (cmd4_reg == rdwa_pkg::CMD_MAP);
            vld6_reg    <= vld5_reg;
            vld7_reg    <= vld6_reg;
            m_valid_reg <= vld7_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (accept) begin
                cmd1_reg <= s_data.cmd;
                dx1_reg  <= dx_next;
                dy1_reg  <= dy_next;
                idx1_reg <= s_data.entry_index;
                val1_reg <= s_data.entry_value;
            end
            cmd2_reg  <= cmd1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            sqx2_reg  <= unsigned'(sqx_next);
            sqy2_reg  <= unsigned'(sqy_next);

            cmd3_reg  <= cmd2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            idx3_reg  <= idx2_reg;
            val3_reg  <= val2_reg;
            n3_reg    <= n_next;

            cmd4_reg  <= cmd3_reg;
            dx4_reg   <= dx3_reg;
            dy4_reg   <= dy3_reg;
            idx4_reg  <= idx3_reg;
            val4_reg  <= val3_reg;
            root4_reg <= root_next;

            dx5_reg   <= dx4_reg;
            dy5_reg   <= dy4_reg;

            px6_reg   <= px_next;
            py6_reg   <= py_next;

            sx7_reg   <= sx_next;
            sy7_reg   <= sy_next;
            fx7_reg   <= fx_next;
            fy7_reg   <= fy_next;

            m_data_reg.source_x       <= sx7_reg;
            m_data_reg.source_y       <= sy7_reg;
            m_data_reg.source_address <= addr_next[ADDR_W-1:0];
            m_data_reg.frac_x         <= fx7_reg;
            m_data_reg.frac_y         <= fy7_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/rdwa_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
module rdwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rdwa_checker.sv =====
`timescale 1ns / 1ps
// port-level assertions for the radial warp address block, bound to the top level
module rdwa_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  rdwa_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rdwa_pkg::PADDR_W-1:0] paddr,
    input  logic [rdwa_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready
);

    localparam int DIM_W = rdwa_pkg::DIM_W;

    // shadow of the registers as seen on the bus
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             bilin_reg;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [2*DIM_W-1:0] addr_calc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rdwa_pkg::WIDTH_RESET;
            height_reg <= rdwa_pkg::HEIGHT_RESET;
            bilin_reg  <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3:2] == rdwa_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= pwdata[DIM_W-1:0];
            end
            if (paddr[3:2] == rdwa_pkg::REG_IMAGE_HEIGHT) begin
                height_reg <= pwdata[DIM_W-1:0];
            end
            if (paddr[3:2] == rdwa_pkg::REG_BILINEAR_ENABLE) begin
                bilin_reg <= pwdata[0];
            end
        end
    end

    assign eff_w     = rdwa_pkg::eff_dim(width_reg);
    assign eff_h     = rdwa_pkg::eff_dim(height_reg);
    assign addr_calc = (2*DIM_W)'(m_data.source_y) * (2*DIM_W)'(eff_w)
                     + (2*DIM_W)'(m_data.source_x);

    // a stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // source stays inside the frame
    a_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (DIM_W'(m_data.source_x) < eff_w) && (DIM_W'(m_data.source_y) < eff_h))
        else $error("source outside the frame");

    // address matches the coordinates
    a_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.source_address == addr_calc[rdwa_pkg::ADDR_W-1:0])
        else $error("source address inconsistent");

    // nearest mode gives zero fractions
    a_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !bilin_reg |-> (m_data.frac_x == '0) && (m_data.frac_y == '0))
        else $error("fraction in nearest mode");

endmodule

bind radial_distance_warp_address rdwa_checker u_rdwa_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the radial distance warp address block
module tb_top;

    localparam int TABLE_DEPTH = rdwa_pkg::TABLE_DEPTH;
    localparam int MAX_DIM     = rdwa_pkg::MAX_DIM;
    localparam int DIM_W       = rdwa_pkg::DIM_W;
    localparam int COORD_W     = rdwa_pkg::COORD_W;
    localparam int IDX_W       = rdwa_pkg::IDX_W;
    localparam int GAIN_W      = rdwa_pkg::GAIN_W;
    localparam int ADDR_W      = rdwa_pkg::ADDR_W;
    localparam int FRAC_W      = rdwa_pkg::FRAC_W;
    localparam int PADDR_W     = rdwa_pkg::PADDR_W;
    localparam int PDATA_W     = rdwa_pkg::PDATA_W;

    localparam int CLK_PERIOD  = 20;
    localparam int PIPE_DRAIN  = 12;          // results trail their item through the pipeline registers
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 36;
    localparam int ITEM_W      = $bits(rdwa_pkg::in_item_t);
    localparam logic [1:0] REG_UNUSED = 2'd3; // first index past the register list

    // clock, reset and block ports
    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    rdwa_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    rdwa_pkg::out_item_t m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // traffic shaping
    int idle_pct  = IDLE_PCT;   // sender gap chance per item
    int stall_pct = IDLE_PCT;   // receiver stall chance per cycle
    int hold_off  = 0;          // cycles the receiver still has to hold m_ready low

    // mirror of the block state used for prediction
    int                  eff_width   = 640;
    int                  eff_height  = 480;
    bit                  bilinear_on = 1'b0;
    int                  gain_mem     [TABLE_DEPTH];
    bit                  gain_written [TABLE_DEPTH];
    rdwa_pkg::out_item_t pending_results [$];
    rdwa_pkg::out_item_t wanted;

    int errors      = 0;
    int cycle_count = 0;

    radial_distance_warp_address dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // a frame size register is limited to 2..MAX_DIM wherever it is used
    function automatic int effective_size(input logic [DIM_W-1:0] d);
        if (d < 2) return 2;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    // gain table slot picked by the coarse root of the squared radius
    function automatic int radius_slot(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row);
        longint dx, dy, n, root;
        bit     found;
        int     j;
        dx = longint'(col) - eff_width / 2;
        dy = longint'(row) - eff_height / 2;
        n  = dx * dx - dx + dy * dy + 256;
        found = 1'b0;
        root  = 0;
        // octaves from the top: threshold drops by four, lookup window by two bits,
        // scale by one bit; the lowest octave catches everything left
        for (j = 0; j < 12; j++) begin
            if (!found && (n >= (longint'(32'h4000_0000) >> (2 * j)) || j == 11)) begin
                root  = rdwa_pkg::ROOT_LUT[(n >> (24 - 2 * j)) & 255];
                root  = (j <= 8) ? (root << (8 - j)) : (root >> (j - 8));
                found = 1'b1;
            end
        end
        // root past the end of the table sticks at the last entry
        return (root >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(root);
    endfunction

    // nearest stops at size-1, bilinear at size-2 so the right/lower neighbor exists
    function automatic longint clamp_coord(input longint c, input longint size);
        if (c < 0) return 0;
        if (bilinear_on) return (c >= size - 1) ? size - 2 : c;
        return (c >= size) ? size - 1 : c;
    endfunction

    function automatic rdwa_pkg::out_item_t map_pixel(input logic [COORD_W-1:0] col,
                                                      input logic [COORD_W-1:0] row);
        longint              half_w, half_h, dx, dy, gain, prod_x, prod_y, sx, sy, addr;
        rdwa_pkg::out_item_t res;
        half_w = eff_width / 2;
        half_h = eff_height / 2;
        dx     = longint'(col) - half_w;
        dy     = longint'(row) - half_h;
        gain   = gain_mem[radius_slot(col, row)];
        prod_x = gain * dx + 128;
        prod_y = gain * dy + 128;
        // arithmetic shift floors negative products
        sx   = clamp_coord(half_w + (prod_x >>> 8), eff_width);
        sy   = clamp_coord(half_h + (prod_y >>> 8), eff_height);
        addr = sy * eff_width + sx;
        res.source_x       = sx[COORD_W-1:0];
        res.source_y       = sy[COORD_W-1:0];
        res.source_address = addr[ADDR_W-1:0];
        // weights come from the unclamped product
        res.frac_x = bilinear_on ? prod_x[FRAC_W-1:0] : '0;
        res.frac_y = bilinear_on ? prod_y[FRAC_W-1:0] : '0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------

    // mostly gains that keep sources inside the frame, some near unity, some anything
    function automatic logic signed [GAIN_W-1:0] random_gain();
        int pick;
        pick = $urandom_range(3);
        if (pick < 2) return GAIN_W'(int'($urandom_range(1024)) - 512);
        if (pick == 2) return GAIN_W'(int'($urandom_range(320, 192)));
        return GAIN_W'($urandom);
    endfunction

    // mostly inside the frame, sometimes anywhere in the field range
    function automatic logic [COORD_W-1:0] random_coord(input int size);
        if ($urandom_range(3) != 0) return COORD_W'($urandom_range(size - 1));
        return COORD_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0) return DIM_W'($urandom_range(64, 2));
        if (pick == 1) return DIM_W'($urandom_range(MAX_DIM, 2));
        return DIM_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one item, hold it until taken, then record what it should cause
    task automatic send_item(input rdwa_pkg::in_item_t item);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (item.cmd == rdwa_pkg::CMD_WRITE) begin
            gain_mem[item.entry_index]     = int'($signed(item.entry_value));
            gain_written[item.entry_index] = 1'b1;
        end else begin
            pending_results.push_back(map_pixel(item.pixel_x, item.pixel_y));
        end
    endtask

    // unused fields of every item carry random bits
    task automatic write_gain(input logic [IDX_W-1:0] idx,
                              input logic signed [GAIN_W-1:0] val);
        rdwa_pkg::in_item_t item;
        item             = ITEM_W'({$urandom, $urandom});
        item.cmd         = rdwa_pkg::CMD_WRITE;
        item.entry_index = idx;
        item.entry_value = val;
        send_item(item);
    endtask

    // a pixel never reads a gain entry that was not written: fill it first
    task automatic request_pixel(input logic [COORD_W-1:0] col,
                                 input logic [COORD_W-1:0] row);
        rdwa_pkg::in_item_t item;
        int                 slot;
        slot = radius_slot(col, row);
        if (!gain_written[slot]) write_gain(IDX_W'(slot), random_gain());
        item         = ITEM_W'({$urandom, $urandom});
        item.cmd     = rdwa_pkg::CMD_MAP;
        item.pixel_x = col;
        item.pixel_y = row;
        send_item(item);
    endtask

    task automatic map_with_gain(input logic [COORD_W-1:0] col,
                                 input logic [COORD_W-1:0] row,
                                 input logic signed [GAIN_W-1:0] val);
        write_gain(IDX_W'(radius_slot(col, row)), val);
        request_pixel(col, row);
    endtask

    // setup cycle then access cycle; the write lands when pready is seen
    task automatic set_register(input logic [1:0] index, input logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (index)
            rdwa_pkg::REG_IMAGE_WIDTH: begin
                eff_width = effective_size(value[DIM_W-1:0]);
            end
            rdwa_pkg::REG_IMAGE_HEIGHT: begin
                eff_height = effective_size(value[DIM_W-1:0]);
            end
            rdwa_pkg::REG_BILINEAR_ENABLE: begin
                bilinear_on = value[0];
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering, collect every result, then let trailing table writes retire
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic bilin);
        drain_pipeline();
        set_register(rdwa_pkg::REG_IMAGE_WIDTH, PDATA_W'(w));
        set_register(rdwa_pkg::REG_IMAGE_HEIGHT, PDATA_W'(h));
        set_register(rdwa_pkg::REG_BILINEAR_ENABLE, PDATA_W'(bilin));
    endtask

    // mostly scattered pixels, some table rewrites, some short raster runs
    task automatic random_traffic(input int count);
        int                 sent, pick, k;
        logic [COORD_W-1:0] col, row;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
                request_pixel(random_coord(eff_width), random_coord(eff_height));
                sent++;
            end else if (pick < 9) begin
                write_gain(IDX_W'($urandom), random_gain());
                sent++;
            end else begin
                col = random_coord(eff_width);
                row = random_coord(eff_height);
                for (k = 0; k < 8; k++) request_pixel(col + COORD_W'(k), row);
                sent += 8;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset frame 640x480, nearest: center, corners, gain extremes, far outside
    task automatic test_center_and_edges();
        write_gain(IDX_W'(0), 20'sh7FFFF);
        map_with_gain(11'd320, 11'd240, 20'sd256);
        map_with_gain(11'd0, 11'd0, 20'sh7FFFF);
        map_with_gain(11'd639, 11'd479, 20'sh80000);
        // squared radius so large the root runs past the table
        map_with_gain(11'd2047, 11'd2047, 20'sd256);
        map_with_gain(11'd2047, 11'd0, 20'sd128);
        map_with_gain(11'd0, 11'd2047, -20'sd256);
    endtask

    // bilinear: weights out, clamp one short of the far edge
    task automatic test_bilinear_clamp();
        set_frame(12'd640, 12'd480, 1'b1);
        map_with_gain(11'd320, 11'd240, 20'sd256);
        map_with_gain(11'd639, 11'd479, 20'sd256);
        map_with_gain(11'd10, 11'd470, 20'sd77);
        map_with_gain(11'd600, 11'd20, -20'sd100);
    endtask

    // size registers below 2 and above the maximum, and a write past the register list
    task automatic test_dimension_limits();
        set_frame(12'd0, 12'd1, 1'b0);
        request_pixel(11'd0, 11'd0);
        request_pixel(11'd1, 11'd1);
        request_pixel(11'd2047, 11'd2047);
        set_frame(12'd4095, 12'd2049, 1'b1);
        request_pixel(11'd2047, 11'd2047);
        request_pixel(11'd1024, 11'd1024);
        drain_pipeline();
        set_register(REG_UNUSED, 32'hFFFF_FFFF);
        request_pixel(11'd5, 11'd2040);
    endtask

    // a run of frame settings, the largest and smallest frames among them
    task automatic test_random_frames();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    set_frame(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), 1'b0);
                end
                1: begin
                    set_frame(12'd2, 12'd2, 1'b1);
                end
                default: begin
                    set_frame(random_dim(), random_dim(), 1'($urandom_range(1)));
                end
            endcase
            random_traffic(50);
        end
    endtask

    // back to back items with the receiver always ready
    task automatic test_streaming_no_idle();
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(100);
        drain_pipeline();
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_output_hold_off();
        drain_pipeline();
        @(posedge aclk);
        hold_off = 300;
        idle_pct = 0;
        random_traffic(60);
        idle_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------
    // receiver, result check, watchdog
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic compare_field(input string name, input logic [ADDR_W-1:0] exp_val,
                                 input logic [ADDR_W-1:0] got_val);
        if (got_val !== exp_val) begin
            errors++;
            $display("%0t ns: %s expected %0d got %0d", $time, name, exp_val, got_val);
        end
    endtask

    // every taken result is matched against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: expected no result, got %h", $time, m_data);
            end else begin
                wanted = pending_results.pop_front();
                compare_field("source_x", ADDR_W'(wanted.source_x), ADDR_W'(m_data.source_x));
                compare_field("source_y", ADDR_W'(wanted.source_y), ADDR_W'(m_data.source_y));
                compare_field("source_address", wanted.source_address, m_data.source_address);
                compare_field("frac_x", ADDR_W'(wanted.frac_x), ADDR_W'(m_data.frac_x));
                compare_field("frac_y", ADDR_W'(wanted.frac_y), ADDR_W'(m_data.frac_y));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_center_and_edges();
        test_bilinear_clamp();
        test_dimension_limits();
        test_random_frames();
        test_streaming_no_idle();
        test_output_hold_off();

        // leftover predictions are caught by the watchdog
        drain_pipeline();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rdwa_pkg.sv
rtl/rdwa_ram.sv
rtl/radial_distance_warp_address.sv
rtl/rdwa_checker.sv
verif/tb_top.sv
